[src/kpd_pkg.sv]
// Shared types, constants and the key-to-ASCII table for the keypad scanner.
// No dependencies; every other file of the block imports this package.
package kpd_pkg;

   localparam int unsigned KEY_COUNT = 16;
   localparam int unsigned KEY_IDX_W = 5;
   localparam int unsigned CHAR_W    = 7;

   typedef logic [KEY_COUNT-1:0] scan_type;
   typedef logic [KEY_IDX_W-1:0] key_idx_type;
   typedef logic [CHAR_W-1:0]    char_type;

   localparam key_idx_type NO_KEY   = 5'd16;
   localparam scan_type    ALL_IDLE = 16'hffff;

   localparam logic ACTION_SHOW  = 1'b0;
   localparam logic ACTION_CLEAR = 1'b1;

   // One result as produced by the key tracker.
   typedef struct packed {
      logic     emit;
      logic     action;
      char_type key_char;
   } key_event_type;

   // Keypad legend, row major: * 0 # D / 7 8 9 C / 4 5 6 B / 1 2 3 A.
   function automatic char_type key_to_char(input key_idx_type key);
      char_type ch;
      ch = '0;
      case (key)
         5'd0:    ch = 7'h2a;
         5'd1:    ch = 7'h30;
         5'd2:    ch = 7'h23;
         5'd3:    ch = 7'h44;
         5'd4:    ch = 7'h37;
         5'd5:    ch = 7'h38;
         5'd6:    ch = 7'h39;
         5'd7:    ch = 7'h43;
         5'd8:    ch = 7'h34;
         5'd9:    ch = 7'h35;
         5'd10:   ch = 7'h36;
         5'd11:   ch = 7'h42;
         5'd12:   ch = 7'h31;
         5'd13:   ch = 7'h32;
         5'd14:   ch = 7'h33;
         5'd15:   ch = 7'h41;
         default: ch = '0;
      endcase
      return ch;
   endfunction

endpackage

[src/kpd_pick_key.sv]
// Priority encoder: first pressed key of one active-low matrix snapshot.
// Depends on kpd_pkg for the scan and key index types.
module kpd_pick_key
   import kpd_pkg::*;
(
   input  scan_type    scan,
   output key_idx_type key
);

   scan_type pressed;

   assign pressed = ~scan;

   // Walk from the last key down so the lowest pressed index wins.
   always_comb begin
      key = NO_KEY;
      for (int i = KEY_COUNT - 1; i >= 0; i--) begin
         if (pressed[i]) begin
            key = key_idx_type'(i);
         end
      end
   end

endmodule

[src/kpd_key_track.sv]
// Debounce decision and change detection: holds the current key and the last
// reported character. Depends on kpd_pkg for types, codes and the key table.
module kpd_key_track
   import kpd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  key_idx_type   first_key,
   input  key_idx_type   second_key,
   output key_event_type key_event,
   output key_idx_type   held_key,
   output char_type      last_char
);

   key_idx_type held_key_ff, held_key_in;
   char_type    last_char_ff, last_char_in;
   char_type    new_char;

   always_comb begin
      held_key_in = held_key_ff;
      if (first_key == second_key && first_key != held_key_ff) begin
         held_key_in = first_key;
      end
      new_char     = key_to_char(held_key_in);
      last_char_in = new_char;

      key_event.emit     = (new_char != last_char_ff);
      key_event.action   = (new_char == '0) ? ACTION_CLEAR : ACTION_SHOW;
      key_event.key_char = new_char;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_key_ff  <= NO_KEY;
         last_char_ff <= '0;
      end else if (advance) begin
         held_key_ff  <= held_key_in;
         last_char_ff <= last_char_in;
      end
   end

   assign held_key  = held_key_ff;
   assign last_char = last_char_ff;

endmodule

[src/keypad_scan_debounce_ascii_unit.sv]
// Top level of the 4x4 keypad scanner with debounce and ASCII mapping.
// Depends on kpd_pkg, kpd_pick_key and kpd_key_track.
//
// Each request carries two active-low 4x4 matrix snapshots taken a debounce
// interval apart. A request is registered; from the registered request the
// first pressed key of each snapshot is found, the held key is updated when
// both agree, and a result is loaded into the output register if the held
// key's character changed: action 0 with the ASCII character, or action 1 with
// character 0 when all keys were released. One request is accepted every
// cycle while the output register can take a result; only a stalled output
// register with a pending result holds up the input register. Requests that
// cause no character change give no response.
module keypad_scan_debounce_ascii_unit
   import kpd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [KEY_COUNT-1:0] req_first_scan,
   input  logic [KEY_COUNT-1:0] req_second_scan,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_action,
   output logic [CHAR_W-1:0]   rsp_key_char
);

   logic          s1_valid_ff, s1_valid_in;
   scan_type      first_scan_ff, second_scan_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_action_ff;
   char_type      rsp_key_char_ff;
   logic          advance;
   key_idx_type   first_key, second_key;
   key_idx_type   held_key;
   char_type      last_char;
   key_event_type key_event;

   // The registered request moves on whenever the output register can take
   // a result, even if this request turns out to produce none.
   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_valid && req_ready) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (advance && key_event.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         first_scan_ff  <= req_first_scan;
         second_scan_ff <= req_second_scan;
      end
      if (advance && key_event.emit) begin
         rsp_action_ff   <= key_event.action;
         rsp_key_char_ff <= key_event.key_char;
      end
   end

   kpd_pick_key u_pick_first (
      .scan (first_scan_ff),
      .key  (first_key)
   );

   kpd_pick_key u_pick_second (
      .scan (second_scan_ff),
      .key  (second_key)
   );

   kpd_key_track u_track (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .first_key  (first_key),
      .second_key (second_key),
      .key_event  (key_event),
      .held_key   (held_key),
      .last_char  (last_char)
   );

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_action   = rsp_action_ff;
   assign rsp_key_char = rsp_key_char_ff;

   // The last reported character always belongs to the held key.
   a_char_matches_key: assert property (@(posedge clock) disable iff (reset)
      last_char == key_to_char(held_key))
      else $error("last character does not match held key");

   // A clear result carries character zero, a show result a nonzero one.
   a_clear_means_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_action == ACTION_CLEAR) == (rsp_key_char == '0)))
      else $error("result action and character disagree");

   // A registered request that cannot move on is kept, not dropped.
   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff)
      else $error("registered request lost while stalled");

   // The input side is open whenever the input register is empty.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_ready)
      else $error("request refused with empty input register");

   // A pending result that is not taken stops the registered request.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !advance)
      else $error("request moved on over a pending result");

endmodule

[tb/tb_keypad_scan_debounce_ascii_unit.sv]
`timescale 1ns / 100ps
// Testbench for keypad_scan_debounce_ascii_unit: directed and random scan pairs are
// checked against a built-in predictor of the held key and the shown character.
// Depends on kpd_pkg and the block's RTL.
module tb_keypad_scan_debounce_ascii_unit;
   import kpd_pkg::*;

   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned LONG_HOLD      = 300;
   localparam int unsigned RANDOM_PAIRS   = 600;
   localparam int unsigned DRAIN_CYCLES   = 10;
   // Legend row by row; the first character sits in the top byte.
   localparam bit [8*KEY_COUNT-1:0] LEGEND = "*0#D789C456B123A";

   typedef struct {
      scan_type    first;
      scan_type    second;
      int unsigned gap;
   } scan_pair_type;

   typedef struct packed {
      logic     action;
      char_type key_char;
   } shown_event_type;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_ready;
   scan_type req_first_scan = ALL_IDLE;
   scan_type req_second_scan = ALL_IDLE;
   logic     rsp_valid;
   logic     rsp_ready = 1'b0;
   logic     rsp_action;
   char_type rsp_key_char;

   scan_pair_type   pending_pairs[$];
   shown_event_type expected_events[$];

   key_idx_type tracked_key;
   char_type    shown_char;
   logic        req_taken = 1'b0;
   int unsigned gap_count = 0;
   int unsigned results_seen = 0;
   int unsigned idle_cycles = 0;
   int unsigned failures = 0;
   int unsigned hold_left = 0;
   int unsigned stall_left = 0;
   bit          hold_done = 1'b0;

   keypad_scan_debounce_ascii_unit u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_first_scan  (req_first_scan),
      .req_second_scan (req_second_scan),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_action      (rsp_action),
      .rsp_key_char    (rsp_key_char)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic key_idx_type first_pressed(input scan_type scan);
      key_idx_type found;
      found = NO_KEY;
      for (int k = KEY_COUNT - 1; k >= 0; k--) begin
         if (!scan[k]) found = key_idx_type'(k);
      end
      return found;
   endfunction

   function automatic char_type legend_char(input key_idx_type key);
      if (key == NO_KEY) return '0;
      return char_type'(LEGEND[8*(KEY_COUNT-1-key) +: 8]);
   endfunction

   // Debounce update and change detection for one accepted request.
   task automatic track_scan_pair(input scan_type first, input scan_type second);
      key_idx_type     key_a;
      key_idx_type     key_b;
      char_type        ch;
      shown_event_type ev;
      key_a = first_pressed(first);
      key_b = first_pressed(second);
      if (key_a == key_b && key_a != tracked_key) tracked_key = key_a;
      ch = legend_char(tracked_key);
      if (ch != shown_char) begin
         shown_char  = ch;
         ev.action   = (ch == '0) ? ACTION_CLEAR : ACTION_SHOW;
         ev.key_char = ch;
         expected_events.push_back(ev);
      end
   endtask

   function automatic int unsigned draw_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic scan_type single_key(input int unsigned k);
      return ALL_IDLE & ~(scan_type'(1) << k);
   endfunction

   // Mostly stable presses and releases, then multi-key patterns, bounces and noise.
   function automatic scan_pair_type random_scan_pair();
      scan_pair_type p;
      int unsigned   mode;
      int unsigned   k;
      scan_type      below;
      mode  = $urandom_range(0, 99);
      k     = $urandom_range(0, KEY_COUNT - 1);
      below = (scan_type'(1) << k) - scan_type'(1);
      if (mode < 45) begin
         p.first  = single_key(k);
         p.second = p.first;
      end else if (mode < 63) begin
         p.first  = ALL_IDLE;
         p.second = ALL_IDLE;
      end else if (mode < 80) begin
         p.first  = (scan_type'($urandom) | below) & single_key(k);
         p.second = p.first;
      end else if (mode < 90) begin
         p.first  = single_key(k);
         p.second = scan_type'($urandom);
      end else begin
         p.first  = scan_type'($urandom);
         p.second = scan_type'($urandom);
      end
      p.gap = draw_gap();
      return p;
   endfunction

   task automatic queue_pair(input scan_type first, input scan_type second);
      scan_pair_type p;
      p.first  = first;
      p.second = second;
      p.gap    = draw_gap();
      pending_pairs.push_back(p);
   endtask

   // Request driver: a new request is offered only once the previous one was taken.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_count = 0;
      end else if (!req_valid || req_taken) begin
         if (pending_pairs.size() != 0 && gap_count < pending_pairs[0].gap) begin
            gap_count++;
            req_valid <= 1'b0;
         end else if (pending_pairs.size() != 0) begin
            req_first_scan  <= pending_pairs[0].first;
            req_second_scan <= pending_pairs[0].second;
            req_valid       <= 1'b1;
            void'(pending_pairs.pop_front());
            gap_count = 0;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response receiver with random stalls, one long hold-off and one stretch
   // with no stalls at all.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (!hold_done && results_seen >= 40) begin
         hold_done = 1'b1;
         hold_left = LONG_HOLD;
         rsp_ready <= 1'b0;
      end else if (results_seen >= 100 && results_seen < 160) begin
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 99) < 60) begin
         rsp_ready <= 1'b1;
      end else begin
         stall_left = draw_gap();
         rsp_ready <= 1'b0;
      end
   end

   // Monitor: records accepted requests, checks responses and runs the watchdog.
   always @(posedge clock) begin
      shown_event_type want;
      if (reset) begin
         tracked_key = NO_KEY;
         shown_char  = '0;
         req_taken   = 1'b0;
         idle_cycles = 0;
      end else begin
         req_taken = req_valid && req_ready;
         if (req_taken) track_scan_pair(req_first_scan, req_second_scan);
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (expected_events.size() == 0) begin
               $display("%0t: unexpected response action=%0b key_char=%h",
                        $time, rsp_action, rsp_key_char);
               failures++;
            end else begin
               want = expected_events.pop_front();
               if (rsp_action !== want.action) begin
                  $display("%0t: action mismatch expected=%0b actual=%0b",
                           $time, want.action, rsp_action);
                  failures++;
               end
               if (rsp_key_char !== want.key_char) begin
                  $display("%0t: key_char mismatch expected=%h actual=%h",
                           $time, want.key_char, rsp_key_char);
                  failures++;
               end
            end
         end
         if (req_taken || (rsp_valid && rsp_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
               $display("%0t: no request or response moved for %0d cycles",
                        $time, idle_cycles);
               $display("tb_keypad_scan_debounce_ascii_unit failed");
               $finish;
            end
         end
      end
   end

   initial begin
      // Nothing pressed after reset, so no response.
      queue_pair(ALL_IDLE, ALL_IDLE);
      // Every key on its own, in scan order.
      for (int k = 0; k < KEY_COUNT; k++) queue_pair(single_key(k), single_key(k));
      // Full release clears the display.
      queue_pair(ALL_IDLE, ALL_IDLE);
      // All keys pressed: the first key in scan order wins, then a repeat gives nothing.
      queue_pair(16'h0000, 16'h0000);
      queue_pair(16'h0000, 16'h0000);
      // Snapshots that disagree keep the held key.
      queue_pair(single_key(5), single_key(6));
      queue_pair(ALL_IDLE, 16'h0000);
      // Several keys in the bottom row only.
      queue_pair(16'h0fff, 16'h0fff);
      queue_pair(ALL_IDLE, ALL_IDLE);
      for (int unsigned i = 0; i < RANDOM_PAIRS; i++) begin
         pending_pairs.push_back(random_scan_pair());
         // A run of back-to-back requests.
         if (i >= 300 && i < 400) pending_pairs[pending_pairs.size() - 1].gap = 0;
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_pairs.size() != 0 || req_valid) @(posedge clock);
      while (expected_events.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      if (expected_events.size() != 0) begin
         $display("%0t: %0d responses never arrived", $time, expected_events.size());
         failures++;
      end
      if (failures == 0) begin
         $display("tb_keypad_scan_debounce_ascii_unit passed");
      end else begin
         $display("tb_keypad_scan_debounce_ascii_unit failed");
      end
      $finish;
   end

endmodule

[filelist.f]
src/kpd_pkg.sv
src/kpd_pick_key.sv
src/kpd_key_track.sv
src/keypad_scan_debounce_ascii_unit.sv
tb/tb_keypad_scan_debounce_ascii_unit.sv
